>>> rtl/core/llpm_pkg.sv
`timescale 1ns / 1ps
package llpm_pkg;

  localparam int NUM_LISTS = 8;
  localparam int NUM_NODES = 32;
  localparam int ITEM_BITS = 32;

  localparam int IDX_W = $clog2(NUM_NODES);
  localparam int PTR_W = IDX_W + 1;
  localparam int LID_W = $clog2(NUM_LISTS);
  localparam int FHC_W = $clog2(NUM_LISTS + 1);
  localparam int CNT_W = $clog2(NUM_NODES + 1);
  localparam int LEN_W = 6;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LID_W-1:0] lid_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam ptr_t NIL = '1;

  typedef enum logic [3:0] {
    CMD_CREATE    = 4'd0,
    CMD_COUNT     = 4'd1,
    CMD_FIRST     = 4'd2,
    CMD_LAST      = 4'd3,
    CMD_NEXT      = 4'd4,
    CMD_PREV      = 4'd5,
    CMD_CURRENT   = 4'd6,
    CMD_INSAFTER  = 4'd7,
    CMD_INSBEFORE = 4'd8,
    CMD_APPEND    = 4'd9,
    CMD_PREPEND   = 4'd10,
    CMD_REMOVE    = 4'd11,
    CMD_TRIM      = 4'd12,
    CMD_CONCAT    = 4'd13,
    CMD_FREE      = 4'd14,
    CMD_SEARCH    = 4'd15
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_HEAD   = 3'd1,
    ST_NO_NODE   = 3'd2,
    ST_NO_CUR    = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PL_BEFORE = 2'd0,
    PL_ITEM   = 2'd1,
    PL_BEYOND = 2'd2
  } place_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc;
    logic ld;
    logic ld2;
    logic exe;
    logic walk;
    logic srd;
    logic scmp;
    logic emit_go;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_concat;
    logic is_free;
    logic is_search;
    logic srch_end;
    logic hit;
    logic more;
    logic slot_free;
  } sts_t;

  function automatic logic ptr_ok(input ptr_t p);
    return p < ptr_t'(NUM_NODES);
  endfunction

endpackage

>>> rtl/core/llpm_ram.sv
`timescale 1ns / 1ps
module llpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/llpm_ctrl.sv
`timescale 1ns / 1ps
module llpm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  llpm_pkg::sts_t sts,
  output llpm_pkg::ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_LOAD2 = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_SRD   = 8'b0010_0000,
    S_SCMP  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one request through load, execute, walk or search, and emit
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = sts.is_concat ? S_LOAD2 : S_EXEC;
      S_LOAD2: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.is_free) state_nxt = S_WALK;
        else if (sts.is_search) state_nxt = S_SRD;
        else state_nxt = S_EMIT;
      end
      S_WALK:  state_nxt = S_EMIT;
      S_SRD:   state_nxt = sts.srch_end ? S_EMIT : S_SCMP;
      S_SCMP:  state_nxt = sts.hit ? S_EMIT : S_SRD;
      S_EMIT: begin
        if (sts.slot_free) state_nxt = sts.more ? S_WALK : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign ctl.acc     = (state_r == S_IDLE) && in_valid;
  assign ctl.ld      = (state_r == S_LOAD);
  assign ctl.ld2     = (state_r == S_LOAD2);
  assign ctl.exe     = (state_r == S_EXEC);
  assign ctl.walk    = (state_r == S_WALK);
  assign ctl.srd     = (state_r == S_SRD);
  assign ctl.scmp    = (state_r == S_SCMP);
  assign ctl.emit_go = (state_r == S_EMIT) && sts.slot_free;

endmodule

>>> rtl/core/llpm_dp.sv
`timescale 1ns / 1ps
module llpm_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  llpm_pkg::ctl_t ctl,
  output llpm_pkg::sts_t sts,
  input  logic [3:0]     in_cmd,
  input  logic [2:0]     in_list_id,
  input  logic [2:0]     in_other_list,
  input  logic [31:0]    in_item_value,
  input  logic [31:0]    in_search_key,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_status,
  output logic [31:0]    out_result_value,
  output logic           out_value_valid,
  output logic [2:0]     out_new_list,
  output logic [5:0]     out_length,
  output logic           out_last
);

  localparam int NN = llpm_pkg::NUM_NODES;
  localparam int NL = llpm_pkg::NUM_LISTS;
  localparam int IW = llpm_pkg::IDX_W;
  localparam int LW = llpm_pkg::LID_W;
  localparam int IB = llpm_pkg::ITEM_BITS;

  // Request registers
  llpm_pkg::cmd_t cmd_r;
  llpm_pkg::lid_t l_r, l2_r;
  logic [IB-1:0]  item_r, key_r;

  // Working copy of the addressed lists
  llpm_pkg::ptr_t   w_hd_r, w_tl_r, w_cur_r, w_hd2_r, w_tl2_r;
  llpm_pkg::len_t   w_len_r, w_len2_r;
  llpm_pkg::place_t w_plc_r;

  // Walk pointer, step count, next free node after the top
  llpm_pkg::ptr_t                n_r, n_nxt, ftn_r;
  logic [llpm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  // Pending result
  llpm_pkg::status_t e_st_r, e_st_nxt;
  llpm_pkg::lid_t    e_nl_r, e_nl_nxt;
  llpm_pkg::len_t    e_len_r, e_len_nxt;
  logic              e_vv_r, e_vv_nxt, e_last_r, e_last_nxt, e_ld;

  // Node links, list table, free pools
  llpm_pkg::ptr_t   nxt_a_r [NN];
  llpm_pkg::ptr_t   prv_a_r [NN];
  llpm_pkg::ptr_t   hd_a_r  [NL];
  llpm_pkg::ptr_t   tl_a_r  [NL];
  llpm_pkg::ptr_t   cur_a_r [NL];
  llpm_pkg::len_t   len_a_r [NL];
  llpm_pkg::place_t plc_a_r [NL];
  llpm_pkg::lid_t   fhs_r   [NL];
  logic [llpm_pkg::FHC_W-1:0] fhc_r, fh_dec;
  llpm_pkg::ptr_t             ft_r, ft_nxt;
  logic [llpm_pkg::CNT_W-1:0] fc_r, fc_nxt;

  // Output register
  logic              out_valid_r;
  llpm_pkg::status_t o_st_r;
  logic [31:0]       o_val_r;
  logic              o_vv_r, o_last_r;
  llpm_pkg::lid_t    o_nl_r;
  llpm_pkg::len_t    o_len_r;

  // Combinational controls
  llpm_pkg::ptr_t   ra, nx_rd, pv_rd, x_n, x_p, x_q;
  logic             on_item, walk_ok, hit;
  llpm_pkg::len_t   len_dec;
  logic             nw0_en, nw1_en, pw0_en, pw1_en;
  llpm_pkg::ptr_t   nw0_a, nw0_d, nw1_a, nw1_d, pw0_a, pw0_d, pw1_a, pw1_d;
  logic             lw_en, lc_en, push_en, pop_en;
  llpm_pkg::lid_t   lc_a, push_id;
  llpm_pkg::ptr_t   lw_hd, lw_tl, lw_cur;
  llpm_pkg::len_t   lw_len;
  llpm_pkg::place_t lw_plc;
  logic             dw_en, dr_en;
  llpm_pkg::ptr_t   dr_a;
  logic [IB-1:0]    rdata;

  assign fh_dec  = fhc_r - 1'b1;
  assign on_item = (w_plc_r == llpm_pkg::PL_ITEM) && llpm_pkg::ptr_ok(w_cur_r);
  assign len_dec = (w_len_r != '0) ? w_len_r - 1'b1 : w_len_r;
  assign walk_ok = llpm_pkg::ptr_ok(n_r) && (cnt_r < llpm_pkg::CNT_W'(NN));
  assign hit     = (rdata == key_r);

  // Single link read address per cycle
  always_comb begin
    if (ctl.ld) ra = ft_r;
    else if (ctl.exe) ra = (cmd_r == llpm_pkg::CMD_TRIM) ? w_tl_r : w_cur_r;
    else ra = n_r;
  end
  assign nx_rd = nxt_a_r[ra[IW-1:0]];
  assign pv_rd = prv_a_r[ra[IW-1:0]];

  // Execute the command, walk free and search chains
  always_comb begin
    nw0_en = 1'b0; nw0_a = '0; nw0_d = '0;
    nw1_en = 1'b0; nw1_a = '0; nw1_d = '0;
    pw0_en = 1'b0; pw0_a = '0; pw0_d = '0;
    pw1_en = 1'b0; pw1_a = '0; pw1_d = '0;
    lw_en = 1'b0; lw_hd = w_hd_r; lw_tl = w_tl_r; lw_cur = w_cur_r;
    lw_len = w_len_r; lw_plc = w_plc_r;
    lc_en = 1'b0; lc_a = '0;
    push_en = 1'b0; push_id = '0; pop_en = 1'b0;
    ft_nxt = ft_r; fc_nxt = fc_r;
    dw_en = 1'b0; dr_en = 1'b0; dr_a = '0;
    x_n = llpm_pkg::NIL; x_p = llpm_pkg::NIL; x_q = llpm_pkg::NIL;
    n_nxt = n_r; cnt_nxt = cnt_r;
    e_ld = 1'b0; e_st_nxt = llpm_pkg::ST_OK; e_vv_nxt = 1'b0; e_nl_nxt = '0;
    e_len_nxt = '0; e_last_nxt = 1'b1;

    if (ctl.exe) begin
      e_ld = (cmd_r != llpm_pkg::CMD_FREE) && (cmd_r != llpm_pkg::CMD_SEARCH);
      case (cmd_r)
        llpm_pkg::CMD_CREATE: begin
          if (fhc_r == '0) begin
            e_st_nxt = llpm_pkg::ST_NO_HEAD;
          end else begin
            pop_en   = 1'b1;
            lc_en    = 1'b1;
            lc_a     = fhs_r[fh_dec[LW-1:0]];
            e_nl_nxt = fhs_r[fh_dec[LW-1:0]];
          end
        end
        llpm_pkg::CMD_FIRST, llpm_pkg::CMD_LAST: begin
          x_n   = (cmd_r == llpm_pkg::CMD_FIRST) ? w_hd_r : w_tl_r;
          lw_en = 1'b1;
          if (!llpm_pkg::ptr_ok(x_n)) begin
            lw_cur = llpm_pkg::NIL; lw_plc = llpm_pkg::PL_BEFORE;
            e_st_nxt = llpm_pkg::ST_NO_CUR;
          end else begin
            lw_cur = x_n; lw_plc = llpm_pkg::PL_ITEM;
            e_vv_nxt = 1'b1; dr_en = 1'b1; dr_a = x_n;
          end
        end
        llpm_pkg::CMD_NEXT, llpm_pkg::CMD_PREV: begin
          if (on_item) begin
            x_n = (cmd_r == llpm_pkg::CMD_NEXT) ? nx_rd : pv_rd;
          end else if (cmd_r == llpm_pkg::CMD_NEXT && w_plc_r == llpm_pkg::PL_BEFORE) begin
            x_n = w_hd_r;
          end else if (cmd_r == llpm_pkg::CMD_PREV && w_plc_r != llpm_pkg::PL_BEFORE) begin
            x_n = w_tl_r;
          end
          lw_en = 1'b1;
          if (!llpm_pkg::ptr_ok(x_n)) begin
            lw_cur = llpm_pkg::NIL;
            lw_plc = (cmd_r == llpm_pkg::CMD_NEXT) ? llpm_pkg::PL_BEYOND
                                                    : llpm_pkg::PL_BEFORE;
            e_st_nxt = llpm_pkg::ST_NO_CUR;
          end else begin
            lw_cur = x_n; lw_plc = llpm_pkg::PL_ITEM;
            e_vv_nxt = 1'b1; dr_en = 1'b1; dr_a = x_n;
          end
        end
        llpm_pkg::CMD_CURRENT: begin
          if (!on_item) begin
            e_st_nxt = llpm_pkg::ST_NO_CUR;
          end else begin
            e_vv_nxt = 1'b1; dr_en = 1'b1; dr_a = w_cur_r;
          end
        end
        llpm_pkg::CMD_INSAFTER, llpm_pkg::CMD_INSBEFORE,
        llpm_pkg::CMD_APPEND, llpm_pkg::CMD_PREPEND: begin
          if (fc_r == '0 || !llpm_pkg::ptr_ok(ft_r)) begin
            e_st_nxt = llpm_pkg::ST_NO_NODE;
          end else begin
            x_n = ft_r;
            // Pick the neighbors of the new node
            if (cmd_r == llpm_pkg::CMD_APPEND ||
                (cmd_r != llpm_pkg::CMD_PREPEND && !on_item &&
                 w_plc_r != llpm_pkg::PL_BEFORE)) begin
              x_p = w_tl_r; x_q = llpm_pkg::NIL;
            end else if (cmd_r == llpm_pkg::CMD_PREPEND || !on_item) begin
              x_p = llpm_pkg::NIL; x_q = w_hd_r;
            end else if (cmd_r == llpm_pkg::CMD_INSAFTER) begin
              x_p = w_cur_r; x_q = nx_rd;
            end else begin
              x_q = w_cur_r; x_p = pv_rd;
            end
            dw_en  = 1'b1;
            nw0_en = 1'b1; nw0_a = x_n; nw0_d = x_q;
            pw0_en = 1'b1; pw0_a = x_n; pw0_d = x_p;
            if (llpm_pkg::ptr_ok(x_p)) begin
              nw1_en = 1'b1; nw1_a = x_p; nw1_d = x_n;
            end else begin
              lw_hd = x_n;
            end
            if (llpm_pkg::ptr_ok(x_q)) begin
              pw1_en = 1'b1; pw1_a = x_q; pw1_d = x_n;
            end else begin
              lw_tl = x_n;
            end
            lw_en = 1'b1; lw_cur = x_n; lw_plc = llpm_pkg::PL_ITEM;
            lw_len = w_len_r + 1'b1;
            ft_nxt = ftn_r; fc_nxt = fc_r - 1'b1;
          end
        end
        llpm_pkg::CMD_REMOVE, llpm_pkg::CMD_TRIM: begin
          x_n = (cmd_r == llpm_pkg::CMD_REMOVE) ? w_cur_r : w_tl_r;
          if ((cmd_r == llpm_pkg::CMD_REMOVE && !on_item) ||
              (cmd_r == llpm_pkg::CMD_TRIM && !llpm_pkg::ptr_ok(x_n))) begin
            e_st_nxt = llpm_pkg::ST_NO_CUR;
          end else begin
            x_p = pv_rd; x_q = nx_rd;
            // Unlink the node
            if (llpm_pkg::ptr_ok(x_p)) begin
              nw0_en = 1'b1; nw0_a = x_p; nw0_d = x_q;
            end else begin
              lw_hd = x_q;
            end
            if (llpm_pkg::ptr_ok(x_q)) begin
              pw0_en = 1'b1; pw0_a = x_q; pw0_d = x_p;
            end else begin
              lw_tl = x_p;
            end
            lw_en = 1'b1; lw_len = len_dec;
            if (cmd_r == llpm_pkg::CMD_REMOVE) begin
              lw_cur = llpm_pkg::ptr_ok(x_q) ? x_q : llpm_pkg::NIL;
              lw_plc = llpm_pkg::ptr_ok(x_q) ? llpm_pkg::PL_ITEM : llpm_pkg::PL_BEYOND;
            end else begin
              lw_cur = llpm_pkg::ptr_ok(lw_tl) ? lw_tl : llpm_pkg::NIL;
              lw_plc = llpm_pkg::ptr_ok(lw_tl) ? llpm_pkg::PL_ITEM : llpm_pkg::PL_BEFORE;
            end
            // Return the node to the pool
            nw1_en = 1'b1; nw1_a = x_n; nw1_d = ft_r;
            pw1_en = 1'b1; pw1_a = x_n; pw1_d = llpm_pkg::NIL;
            ft_nxt = x_n; fc_nxt = fc_r + 1'b1;
            e_vv_nxt = 1'b1; dr_en = 1'b1; dr_a = x_n;
          end
        end
        llpm_pkg::CMD_CONCAT: begin
          if (l_r != l2_r) begin
            if (llpm_pkg::ptr_ok(w_hd2_r)) begin
              lw_en = 1'b1; lw_tl = w_tl2_r;
              if (!llpm_pkg::ptr_ok(w_tl_r)) begin
                lw_hd = w_hd2_r; lw_len = w_len2_r;
              end else begin
                nw0_en = 1'b1; nw0_a = w_tl_r; nw0_d = w_hd2_r;
                pw0_en = 1'b1; pw0_a = w_hd2_r; pw0_d = w_tl_r;
                lw_len = w_len_r + w_len2_r;
              end
            end
            lc_en = 1'b1; lc_a = l2_r;
            push_en = (fhc_r < llpm_pkg::FHC_W'(NL)); push_id = l2_r;
          end
        end
        llpm_pkg::CMD_FREE: begin
          lw_en = 1'b1; lw_hd = llpm_pkg::NIL; lw_tl = llpm_pkg::NIL;
          lw_cur = llpm_pkg::NIL; lw_len = '0; lw_plc = llpm_pkg::PL_BEFORE;
          push_en = (fhc_r < llpm_pkg::FHC_W'(NL)); push_id = l_r;
          n_nxt = w_hd_r; cnt_nxt = '0;
        end
        llpm_pkg::CMD_SEARCH: begin
          if (on_item) n_nxt = w_cur_r;
          else if (w_plc_r == llpm_pkg::PL_BEFORE) n_nxt = w_hd_r;
          else n_nxt = w_tl_r;
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
      e_len_nxt = (cmd_r == llpm_pkg::CMD_CREATE) ? '0 : lw_len;
    end

    // Free: release one node and report it
    if (ctl.walk) begin
      e_ld = 1'b1;
      if (walk_ok) begin
        x_q    = nx_rd;
        nw0_en = 1'b1; nw0_a = n_r; nw0_d = ft_r;
        pw0_en = 1'b1; pw0_a = n_r; pw0_d = llpm_pkg::NIL;
        ft_nxt = n_r; fc_nxt = fc_r + 1'b1;
        dr_en  = 1'b1; dr_a = n_r;
        n_nxt  = x_q; cnt_nxt = cnt_r + 1'b1;
        e_vv_nxt   = 1'b1;
        e_last_nxt = !llpm_pkg::ptr_ok(x_q) ||
                     (cnt_r == llpm_pkg::CNT_W'(NN - 1));
      end
    end

    // Search: fetch the next stored item or give up
    if (ctl.srd) begin
      if (walk_ok) begin
        dr_en = 1'b1; dr_a = n_r;
      end else begin
        lw_en = 1'b1; lw_cur = llpm_pkg::NIL; lw_plc = llpm_pkg::PL_BEYOND;
        e_ld = 1'b1; e_st_nxt = llpm_pkg::ST_NOT_FOUND; e_len_nxt = w_len_r;
      end
    end

    // Search: compare and advance
    if (ctl.scmp) begin
      if (hit) begin
        lw_en = 1'b1; lw_cur = n_r; lw_plc = llpm_pkg::PL_ITEM;
        e_ld = 1'b1; e_vv_nxt = 1'b1; e_len_nxt = w_len_r;
      end else begin
        n_nxt = nx_rd; cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Item store
  llpm_ram #(.WIDTH(IB), .DEPTH(NN)) u_data (
    .clk   (clk),
    .we    (dw_en),
    .waddr (ft_r[IW-1:0]),
    .wdata (item_r),
    .re    (dr_en),
    .raddr (dr_a[IW-1:0]),
    .rdata (rdata)
  );

  // Request and working registers
  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      cmd_r  <= llpm_pkg::cmd_t'(in_cmd);
      l_r    <= in_list_id[LW-1:0];
      l2_r   <= in_other_list[LW-1:0];
      item_r <= in_item_value[IB-1:0];
      key_r  <= in_search_key[IB-1:0];
    end
    if (ctl.ld) begin
      w_hd_r  <= hd_a_r[l_r];
      w_tl_r  <= tl_a_r[l_r];
      w_cur_r <= cur_a_r[l_r];
      w_len_r <= len_a_r[l_r];
      w_plc_r <= plc_a_r[l_r];
      ftn_r   <= nx_rd;
    end
    if (ctl.ld2) begin
      w_hd2_r  <= hd_a_r[l2_r];
      w_tl2_r  <= tl_a_r[l2_r];
      w_len2_r <= len_a_r[l2_r];
    end
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
    if (e_ld) begin
      e_st_r   <= e_st_nxt;
      e_vv_r   <= e_vv_nxt;
      e_nl_r   <= e_nl_nxt;
      e_len_r  <= e_len_nxt;
      e_last_r <= e_last_nxt;
    end
    if (ctl.emit_go) begin
      o_st_r   <= e_st_r;
      o_val_r  <= e_vv_r ? 32'(rdata) : '0;
      o_vv_r   <= e_vv_r;
      o_nl_r   <= e_nl_r;
      o_len_r  <= e_len_r;
      o_last_r <= e_last_r;
    end
  end

  // Pool state: links, list table, free stacks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NN; i++) begin
        nxt_a_r[i] <= (i == 0) ? llpm_pkg::NIL : llpm_pkg::ptr_t'(i - 1);
        prv_a_r[i] <= (i + 1 < NN) ? llpm_pkg::ptr_t'(i + 1) : llpm_pkg::NIL;
      end
      for (int j = 0; j < NL; j++) begin
        hd_a_r[j]  <= llpm_pkg::NIL;
        tl_a_r[j]  <= llpm_pkg::NIL;
        cur_a_r[j] <= llpm_pkg::NIL;
        len_a_r[j] <= '0;
        plc_a_r[j] <= llpm_pkg::PL_BEFORE;
        fhs_r[j]   <= llpm_pkg::lid_t'(j);
      end
      fhc_r <= llpm_pkg::FHC_W'(NL);
      ft_r  <= llpm_pkg::ptr_t'(NN - 1);
      fc_r  <= llpm_pkg::CNT_W'(NN);
    end else begin
      if (nw0_en) nxt_a_r[nw0_a[IW-1:0]] <= nw0_d;
      if (nw1_en) nxt_a_r[nw1_a[IW-1:0]] <= nw1_d;
      if (pw0_en) prv_a_r[pw0_a[IW-1:0]] <= pw0_d;
      if (pw1_en) prv_a_r[pw1_a[IW-1:0]] <= pw1_d;
      if (lc_en) begin
        hd_a_r[lc_a]  <= llpm_pkg::NIL;
        tl_a_r[lc_a]  <= llpm_pkg::NIL;
        cur_a_r[lc_a] <= llpm_pkg::NIL;
        len_a_r[lc_a] <= '0;
        plc_a_r[lc_a] <= llpm_pkg::PL_BEFORE;
      end
      if (lw_en) begin
        hd_a_r[l_r]  <= lw_hd;
        tl_a_r[l_r]  <= lw_tl;
        cur_a_r[l_r] <= lw_cur;
        len_a_r[l_r] <= lw_len;
        plc_a_r[l_r] <= lw_plc;
      end
      if (pop_en) fhc_r <= fh_dec;
      if (push_en) begin
        fhs_r[fhc_r[LW-1:0]] <= push_id;
        fhc_r <= fhc_r + 1'b1;
      end
      ft_r <= ft_nxt;
      fc_r <= fc_nxt;
    end
  end

  // Output valid: set on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.is_concat = (cmd_r == llpm_pkg::CMD_CONCAT);
  assign sts.is_free   = (cmd_r == llpm_pkg::CMD_FREE);
  assign sts.is_search = (cmd_r == llpm_pkg::CMD_SEARCH);
  assign sts.srch_end  = !walk_ok;
  assign sts.hit       = hit;
  assign sts.more      = (cmd_r == llpm_pkg::CMD_FREE) && !e_last_r;
  assign sts.slot_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = o_st_r;
  assign out_result_value = o_val_r;
  assign out_value_valid  = o_vv_r;
  assign out_new_list     = 3'(o_nl_r);
  assign out_length       = o_len_r;
  assign out_last         = o_last_r;

endmodule

>>> rtl/core/linked_list_pool_manager_top.sv
`timescale 1ns / 1ps
// A request passes through load (a second load for concat), execute and emit states.
// Search alternates a read and a compare state per node visited; free walks one node per result.
// One request at a time, set by the control sequencer and the
// single read port of the item store; a new request is taken once all results are out.
// Reset (rst_n, synchronous, active low) chains all nodes into the free pool,
// clears every list and restores list ids 0 to 7 to the free stack.
module linked_list_pool_manager_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [2:0]  in_list_id,
  input  logic [2:0]  in_other_list,
  input  logic [31:0] in_item_value,
  input  logic [31:0] in_search_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_value,
  output logic        out_value_valid,
  output logic [2:0]  out_new_list,
  output logic [5:0]  out_length,
  output logic        out_last
);

  llpm_pkg::ctl_t ctl;
  llpm_pkg::sts_t sts;

  // Control sequencer
  llpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Pool datapath
  llpm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_list_id       (in_list_id),
    .in_other_list    (in_other_list),
    .in_item_value    (in_item_value),
    .in_search_key    (in_search_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_value_valid  (out_value_valid),
    .out_new_list     (out_new_list),
    .out_length       (out_length),
    .out_last         (out_last)
  );

endmodule

>>> rtl/core/llpm_chk.sv
`timescale 1ns / 1ps
module llpm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [3:0]  in_cmd,
  input logic [2:0]  in_list_id,
  input logic [2:0]  in_other_list,
  input logic [31:0] in_item_value,
  input logic [31:0] in_search_key,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_result_value,
  input logic        out_value_valid,
  input logic [2:0]  out_new_list,
  input logic [5:0]  out_length,
  input logic        out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_status)
    && $stable(out_last))
    else $error("stalled result changed");

  // One request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // Status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == 3'd0 || out_status == 3'd1 || out_status == 3'd2 ||
                   out_status == 3'd3 || out_status == 3'd4))
    else $error("bad status code");

  // No item means a zero value
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_valid |-> out_result_value == 32'd0)
    else $error("value without item");

  // An error is a single, final result without an item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'd0 |-> out_last && !out_value_valid)
    else $error("error result not final");

endmodule

bind linked_list_pool_manager_top llpm_chk u_llpm_chk (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import llpm_pkg::*;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  lid;
    logic [2:0]  lid2;
    logic [31:0] item;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic        vv;
    logic [2:0]  nl;
    logic [5:0]  len;
    logic        lst;
  } rsp_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [3:0]  in_cmd = '0;
  logic [2:0]  in_list_id = '0;
  logic [2:0]  in_other_list = '0;
  logic [31:0] in_item_value = '0;
  logic [31:0] in_search_key = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_status;
  logic [31:0] out_result_value;
  logic        out_value_valid;
  logic [2:0]  out_new_list;
  logic [5:0]  out_length;
  logic        out_last;

  linked_list_pool_manager_top DUT (.*);

  always #10 clk = ~clk;

  // Shadow copy of the pool
  logic [31:0] sh_data [NUM_NODES];
  logic [7:0]  sh_next [NUM_NODES];
  logic [7:0]  sh_prev [NUM_NODES];
  logic [7:0]  sh_ftop, sh_fcnt;
  logic [7:0]  sh_head [NUM_LISTS];
  logic [7:0]  sh_tail [NUM_LISTS];
  logic [7:0]  sh_cur  [NUM_LISTS];
  logic [7:0]  sh_len  [NUM_LISTS];
  logic [1:0]  sh_place[NUM_LISTS];
  logic [2:0]  sh_hstk [NUM_LISTS];
  logic [7:0]  sh_hcnt;
  logic [31:0] written_mask;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle = 0, recv_stall = 0;
  logic done = 0;

  function automatic bit nok(logic [7:0] n);
    return n < NUM_NODES;
  endfunction

  function automatic bit on_item(int l);
    return sh_place[l] == PL_ITEM && nok(sh_cur[l]);
  endfunction

  task automatic push_rsp(logic [2:0] st, logic [31:0] v, logic vv, logic [2:0] nl,
                          logic [7:0] len, logic lst);
    rsp_t r;
    r.status = st; r.value = v; r.vv = vv; r.nl = nl; r.len = len[5:0]; r.lst = lst;
    expected_rsps.push_back(r);
  endtask

  task automatic clear_list(int l);
    sh_head[l] = 8'hFF; sh_tail[l] = 8'hFF; sh_cur[l] = 8'hFF;
    sh_len[l] = 0; sh_place[l] = PL_BEFORE;
  endtask

  task automatic push_id(int l);
    if (sh_hcnt < NUM_LISTS) begin
      sh_hstk[sh_hcnt] = l[2:0];
      sh_hcnt++;
    end
  endtask

  task automatic release_node(logic [7:0] n);
    sh_next[n] = sh_ftop; sh_prev[n] = 8'hFF;
    sh_ftop = n; sh_fcnt++;
  endtask

  task automatic unlink(int l, logic [7:0] n);
    logic [7:0] p, q;
    p = sh_prev[n]; q = sh_next[n];
    if (nok(p)) sh_next[p] = q; else sh_head[l] = q;
    if (nok(q)) sh_prev[q] = p; else sh_tail[l] = p;
    if (sh_len[l] > 0) sh_len[l]--;
  endtask

  task automatic reset_pool();
    for (int i = 0; i < NUM_NODES; i++) begin
      sh_data[i] = '0;
      sh_next[i] = (i == 0) ? 8'hFF : 8'(i - 1);
      sh_prev[i] = (i + 1 < NUM_NODES) ? 8'(i + 1) : 8'hFF;
    end
    sh_ftop = NUM_NODES - 1; sh_fcnt = NUM_NODES;
    for (int i = 0; i < NUM_LISTS; i++) begin
      clear_list(i);
      sh_hstk[i] = i[2:0];
    end
    sh_hcnt = NUM_LISTS;
    written_mask = '0;
  endtask

  // Compute the results one request produces and advance the shadow pool
  task automatic predict_pool(req_t r);
    int l, l2, k;
    logic [7:0] n, p, q;
    bit hit;
    l = r.lid; l2 = r.lid2;
    case (cmd_t'(r.cmd))
      CMD_CREATE: begin
        if (sh_hcnt == 0) push_rsp(ST_NO_HEAD, 0, 0, 0, 0, 1);
        else begin
          sh_hcnt--;
          l = sh_hstk[sh_hcnt];
          clear_list(l);
          push_rsp(ST_OK, 0, 0, l[2:0], 0, 1);
        end
      end
      CMD_COUNT: push_rsp(ST_OK, 0, 0, 0, sh_len[l], 1);
      CMD_FIRST, CMD_LAST: begin
        n = (r.cmd == CMD_FIRST) ? sh_head[l] : sh_tail[l];
        if (!nok(n)) begin
          sh_cur[l] = 8'hFF; sh_place[l] = PL_BEFORE;
          push_rsp(ST_NO_CUR, 0, 0, 0, sh_len[l], 1);
        end else begin
          sh_cur[l] = n; sh_place[l] = PL_ITEM;
          push_rsp(ST_OK, sh_data[n], 1, 0, sh_len[l], 1);
        end
      end
      CMD_NEXT, CMD_PREV: begin
        if (on_item(l)) n = (r.cmd == CMD_NEXT) ? sh_next[sh_cur[l]] : sh_prev[sh_cur[l]];
        else if (r.cmd == CMD_NEXT && sh_place[l] == PL_BEFORE) n = sh_head[l];
        else if (r.cmd == CMD_PREV && sh_place[l] != PL_BEFORE) n = sh_tail[l];
        else n = 8'hFF;
        if (!nok(n)) begin
          sh_cur[l] = 8'hFF;
          sh_place[l] = (r.cmd == CMD_NEXT) ? PL_BEYOND : PL_BEFORE;
          push_rsp(ST_NO_CUR, 0, 0, 0, sh_len[l], 1);
        end else begin
          sh_cur[l] = n; sh_place[l] = PL_ITEM;
          push_rsp(ST_OK, sh_data[n], 1, 0, sh_len[l], 1);
        end
      end
      CMD_CURRENT: begin
        if (!on_item(l)) push_rsp(ST_NO_CUR, 0, 0, 0, sh_len[l], 1);
        else push_rsp(ST_OK, sh_data[sh_cur[l]], 1, 0, sh_len[l], 1);
      end
      CMD_INSAFTER, CMD_INSBEFORE, CMD_APPEND, CMD_PREPEND: begin
        n = sh_ftop;
        if (sh_fcnt == 0 || !nok(n)) push_rsp(ST_NO_NODE, 0, 0, 0, sh_len[l], 1);
        else begin
          sh_ftop = sh_next[n]; sh_fcnt--;
          sh_data[n] = r.item; written_mask[n] = 1'b1;
          if (r.cmd == CMD_APPEND ||
              (r.cmd != CMD_PREPEND && !on_item(l) && sh_place[l] != PL_BEFORE)) begin
            p = sh_tail[l]; q = 8'hFF;
          end else if (r.cmd == CMD_PREPEND || !on_item(l)) begin
            p = 8'hFF; q = sh_head[l];
          end else if (r.cmd == CMD_INSAFTER) begin
            p = sh_cur[l]; q = sh_next[p];
          end else begin
            q = sh_cur[l]; p = sh_prev[q];
          end
          sh_prev[n] = p; sh_next[n] = q;
          if (nok(p)) sh_next[p] = n; else sh_head[l] = n;
          if (nok(q)) sh_prev[q] = n; else sh_tail[l] = n;
          sh_cur[l] = n; sh_place[l] = PL_ITEM;
          sh_len[l]++;
          push_rsp(ST_OK, 0, 0, 0, sh_len[l], 1);
        end
      end
      CMD_REMOVE: begin
        if (!on_item(l)) push_rsp(ST_NO_CUR, 0, 0, 0, sh_len[l], 1);
        else begin
          n = sh_cur[l]; q = sh_next[n];
          unlink(l, n);
          sh_cur[l] = nok(q) ? q : 8'hFF;
          sh_place[l] = nok(q) ? PL_ITEM : PL_BEYOND;
          push_rsp(ST_OK, sh_data[n], 1, 0, sh_len[l], 1);
          release_node(n);
        end
      end
      CMD_TRIM: begin
        n = sh_tail[l];
        if (!nok(n)) push_rsp(ST_NO_CUR, 0, 0, 0, sh_len[l], 1);
        else begin
          unlink(l, n);
          p = sh_tail[l];
          sh_cur[l] = nok(p) ? p : 8'hFF;
          sh_place[l] = nok(p) ? PL_ITEM : PL_BEFORE;
          push_rsp(ST_OK, sh_data[n], 1, 0, sh_len[l], 1);
          release_node(n);
        end
      end
      CMD_CONCAT: begin
        if (l != l2) begin
          if (nok(sh_head[l2])) begin
            if (!nok(sh_tail[l])) begin
              sh_head[l] = sh_head[l2]; sh_tail[l] = sh_tail[l2]; sh_len[l] = sh_len[l2];
            end else begin
              sh_next[sh_tail[l]] = sh_head[l2];
              sh_prev[sh_head[l2]] = sh_tail[l];
              sh_tail[l] = sh_tail[l2];
              sh_len[l] = sh_len[l] + sh_len[l2];
            end
          end
          clear_list(l2);
          push_id(l2);
        end
        push_rsp(ST_OK, 0, 0, 0, sh_len[l], 1);
      end
      CMD_FREE: begin
        k = 0;
        n = sh_head[l];
        while (nok(n) && k < NUM_NODES) begin
          q = sh_next[n];
          push_rsp(ST_OK, sh_data[n], 1, 0, 0, !(nok(q) && k + 1 < NUM_NODES));
          release_node(n);
          k++;
          n = q;
        end
        if (k == 0) push_rsp(ST_OK, 0, 0, 0, 0, 1);
        clear_list(l);
        push_id(l);
      end
      default: begin
        if (on_item(l)) n = sh_cur[l];
        else if (sh_place[l] == PL_BEFORE) n = sh_head[l];
        else n = sh_tail[l];
        hit = 0;
        for (int s = 0; s < NUM_NODES && nok(n) && !hit; s++) begin
          if (sh_data[n] == r.key) begin
            hit = 1;
            sh_cur[l] = n; sh_place[l] = PL_ITEM;
            push_rsp(ST_OK, sh_data[n], 1, 0, sh_len[l], 1);
          end else n = sh_next[n];
        end
        if (!hit) begin
          sh_cur[l] = 8'hFF; sh_place[l] = PL_BEYOND;
          push_rsp(ST_NOT_FOUND, 0, 0, 0, sh_len[l], 1);
        end
      end
    endcase
  endtask

  // Driver: present queued requests, hold while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pool(pending_reqs.pop_front());
      end
      if ((!in_valid || !in_stall) && pending_reqs.size() > 0 &&
          !($urandom_range(99) < send_idle) &&
          !(in_valid && !in_stall && pending_reqs.size() == 0)) begin
        in_valid      <= 1'b1;
        in_cmd        <= pending_reqs[0].cmd;
        in_list_id    <= pending_reqs[0].lid;
        in_other_list <= pending_reqs[0].lid2;
        in_item_value <= pending_reqs[0].item;
        in_search_key <= pending_reqs[0].key;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result st=%0d val=%h", $time, out_status,
                   out_result_value);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_status !== e.status || out_result_value !== e.value ||
              out_value_valid !== e.vv || out_new_list !== e.nl ||
              out_length !== e.len || out_last !== e.lst) begin
            $display("%0t: mismatch expected st=%0d val=%h vv=%0d nl=%0d len=%0d last=%0d",
                     $time, e.status, e.value, e.vv, e.nl, e.len, e.lst);
            $display("%0t:          actual   st=%0d val=%h vv=%0d nl=%0d len=%0d last=%0d",
                     $time, out_status, out_result_value, out_value_valid,
                     out_new_list, out_length, out_last);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // Planning model state for list contents; the stimulus below does not use it
  int  plan_len [NUM_LISTS];
  int  plan_free;
  logic [31:0] plan_vals[$];

  task automatic queue_req(logic [3:0] c, int l, int l2, logic [31:0] v, logic [31:0] k);
    req_t r;
    r.cmd = c; r.lid = l[2:0]; r.lid2 = l2[2:0]; r.item = v; r.key = k;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    reset_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 66; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (ph == 0) begin
        // Directed: empty-list corner cases, every command, extremes of the fields
        queue_req(CMD_CREATE, 0, 0, 0, 0);
        queue_req(CMD_FIRST, 7, 0, 0, 0);
        queue_req(CMD_LAST, 7, 0, 0, 0);
        queue_req(CMD_PREV, 7, 0, 0, 0);
        queue_req(CMD_NEXT, 7, 0, 0, 0);
        queue_req(CMD_NEXT, 7, 0, 0, 0);
        queue_req(CMD_CURRENT, 7, 0, 0, 0);
        queue_req(CMD_REMOVE, 7, 0, 0, 0);
        queue_req(CMD_TRIM, 7, 0, 0, 0);
        queue_req(CMD_INSAFTER, 7, 0, 32'hFFFF_FFFF, 0);
        queue_req(CMD_INSBEFORE, 7, 0, 32'h0, 0);
        queue_req(CMD_APPEND, 7, 0, 32'hA5A5_5A5A, 0);
        queue_req(CMD_PREPEND, 7, 0, 32'h5A5A_A5A5, 0);
        queue_req(CMD_SEARCH, 7, 0, 0, 32'hA5A5_5A5A);
        queue_req(CMD_SEARCH, 7, 0, 0, 32'h1234_5678);
        queue_req(CMD_PREV, 7, 0, 0, 0);
        queue_req(CMD_REMOVE, 7, 0, 0, 0);
        queue_req(CMD_COUNT, 7, 0, 0, 0);
        queue_req(CMD_CONCAT, 7, 7, 0, 0);
        queue_req(CMD_APPEND, 6, 0, 32'h0000_0001, 0);
        queue_req(CMD_CONCAT, 7, 6, 0, 0);
        queue_req(CMD_FREE, 7, 0, 0, 0);
        queue_req(CMD_FREE, 5, 0, 0, 0);
        for (int i = 0; i < 9; i++) queue_req(CMD_CREATE, 0, 0, 0, 0);
        // Fill the pool to exhaustion
        for (int i = 0; i < 33; i++) queue_req(CMD_APPEND, i % 8, 0, $urandom, 0);
        for (int i = 0; i < 8; i++) queue_req(CMD_FREE, i, 0, 0, 0);
      end else begin
        // Random: mostly inserts and walks, some free and concat to recycle nodes
        for (int i = 0; i < 70; i++) begin
          logic [3:0] c;
          int l, l2;
          l = $urandom_range(7); l2 = $urandom_range(7);
          c = $urandom_range(15);
          if ($urandom_range(3) == 0) c = 4'($urandom_range(CMD_INSAFTER, CMD_PREPEND));
          if (c == CMD_FREE && $urandom_range(2) != 0) c = CMD_SEARCH;
          queue_req(c, l, l2, rand_word(), rand_word());
        end
        for (int i = 0; i < 8; i++) queue_req(CMD_FREE, i, 0, 0, 0);
      end
      wait_drain();
    end
    done = 1;
  end

  // End of run and timeout
  always @(posedge clk) begin
    if (done) begin
      if (errors == 0) $display("PASS linked_list_pool_manager_top");
      else $display("FAIL linked_list_pool_manager_top");
      $finish;
    end else if (cycles > 400000) begin
      $display("FAIL linked_list_pool_manager_top");
      $finish;
    end
  end

endmodule
